// File: hw/rtl/cpt_pkg.sv
package cpt_pkg;

  // Magnitude width of the result in cents; the result carries one sign bit more.
  localparam int MAG_BITS = 47;
  localparam int CENTS_W  = MAG_BITS + 1;
  // Room for ten times a magnitude plus a digit's worth of dollars.
  localparam int ACC_W    = MAG_BITS + 4;

  localparam logic [63:0] MAX_MAG64 = (64'd1 << MAG_BITS) - 64'd1;
  // Largest whole-dollar amount, in cents, that still fits the magnitude.
  localparam logic [63:0] DMAX100_64 = MAX_MAG64 - (MAX_MAG64 % 64'd100);

  localparam logic [MAG_BITS-1:0] MAX_MAG = MAX_MAG64[MAG_BITS-1:0];
  localparam logic [MAG_BITS-1:0] DMAX100 = DMAX100_64[MAG_BITS-1:0];

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_SIGN  = 3'b010,
    PH_BODY  = 3'b100
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_BAD_DOL = 3'd2,
    ST_BAD_CNT = 3'd3,
    ST_OVER    = 3'd4
  } status_e;

  typedef struct packed {
    phase_e              phase;
    logic                neg;
    logic                paren;
    logic                close_pend;
    logic                in_frac;
    logic [1:0]          frac_cnt;
    logic [MAG_BITS-1:0] x100;      // dollars so far, kept in cents
    logic [6:0]          cent;
    logic                round;
    logic                err_dol;
    logic                err_cent;
    logic                err_over;
  } state_t;

  localparam state_t STATE_RESET = '{phase: PH_START, default: '0};

  // Snapshot of a finished text, handed to the output stage.
  typedef struct packed {
    status_e             status;
    logic                neg;
    logic [MAG_BITS-1:0] x100;
    logic [6:0]          cent;
    logic                round;
  } fin_t;

  function automatic logic [6:0] digit_x10(input logic [3:0] d);
    logic [6:0] r;
    r = {3'b000, d} * 7'd10;
    return r;
  endfunction

  function automatic logic [9:0] digit_x100(input logic [3:0] d);
    logic [9:0] r;
    r = {6'b000000, d} * 10'd100;
    return r;
  endfunction

endpackage

// File: hw/rtl/cpt_in_if.sv
interface cpt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

// File: hw/rtl/cpt_out_if.sv
interface cpt_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [cpt_pkg::CENTS_W-1:0] cents;
  logic        [2:0]                  status;

  modport source (output valid, output cents, output status, input ready);
  modport sink   (input valid, input cents, input status, output ready);
endinterface

// File: hw/rtl/cpt_char_step.sv
module cpt_char_step (
  input  cpt_pkg::state_t state_i,
  input  logic [7:0]      ch_i,
  output cpt_pkg::state_t state_o
);

  logic                              blank;
  logic                              is_digit;
  logic [3:0]                        dig;
  logic [cpt_pkg::ACC_W-1:0]         acc_x10;
  logic [cpt_pkg::ACC_W-1:0]         acc_nxt;
  logic                              acc_over;
  logic                              body;
  cpt_pkg::state_t                   s;

  assign blank    = (ch_i == cpt_pkg::CH_SPACE) ||
                    ((ch_i >= cpt_pkg::CH_TAB) && (ch_i <= cpt_pkg::CH_CR));
  assign is_digit = (ch_i >= cpt_pkg::CH_ZERO) && (ch_i <= cpt_pkg::CH_NINE);
  assign dig      = ch_i[3:0];

  // x100 * 10 + digit * 100, then range check against the dollar limit
  assign acc_x10  = {1'b0, state_i.x100, 3'b000} + {3'b000, state_i.x100, 1'b0};
  assign acc_nxt  = acc_x10 + cpt_pkg::ACC_W'(cpt_pkg::digit_x100(dig));
  assign acc_over = acc_nxt > {4'b0000, cpt_pkg::DMAX100};

  always_comb begin
    s    = state_i;
    body = 1'b0;
    if (!blank) begin
      // a held ')' followed by more text is an ordinary (bad) character
      if (s.close_pend) begin
        s.close_pend = 1'b0;
        s.phase      = cpt_pkg::PH_BODY;
        if (s.in_frac) begin
          s.err_cent = 1'b1;
        end else begin
          s.err_dol = 1'b1;
        end
      end
      if ((ch_i == cpt_pkg::CH_RPAREN) && s.paren && (s.phase != cpt_pkg::PH_START)) begin
        s.close_pend = 1'b1;
      end else begin
        unique case (s.phase)
          cpt_pkg::PH_START: begin
            if (ch_i == cpt_pkg::CH_LPAREN) begin
              s.paren = 1'b1;
              s.neg   = 1'b1;
              s.phase = cpt_pkg::PH_SIGN;
            end else if (ch_i == cpt_pkg::CH_MINUS) begin
              s.neg   = 1'b1;
              s.phase = cpt_pkg::PH_SIGN;
            end else begin
              s.phase = cpt_pkg::PH_BODY;
              body    = (ch_i != cpt_pkg::CH_DOLLAR);
            end
          end
          cpt_pkg::PH_SIGN: begin
            s.phase = cpt_pkg::PH_BODY;
            body    = (ch_i != cpt_pkg::CH_DOLLAR);
          end
          default: begin
            body = 1'b1;
          end
        endcase

        if (body) begin
          priority if (ch_i == cpt_pkg::CH_COMMA) begin
            s.in_frac = s.in_frac;
          end else if (ch_i == cpt_pkg::CH_DOT) begin
            if (s.in_frac) begin
              s.err_cent = 1'b1;
            end
            s.in_frac = 1'b1;
          end else if (is_digit) begin
            if (!s.in_frac) begin
              if (acc_over) begin
                s.err_over = 1'b1;
                s.x100     = cpt_pkg::DMAX100;
              end else begin
                s.x100 = acc_nxt[cpt_pkg::MAG_BITS-1:0];
              end
            end else begin
              unique case (s.frac_cnt)
                2'd0:    s.cent  = cpt_pkg::digit_x10(dig);
                2'd1:    s.cent  = s.cent + {3'b000, dig};
                2'd2:    s.round = (dig >= 4'd5);
                default: s.round = s.round;
              endcase
              if (s.frac_cnt != 2'd3) begin
                s.frac_cnt = s.frac_cnt + 2'd1;
              end
            end
          end else begin
            if (s.in_frac) begin
              s.err_cent = 1'b1;
            end else begin
              s.err_dol = 1'b1;
            end
          end
        end
      end
    end
    state_o = s;
  end

endmodule

// File: hw/rtl/currency_text_to_cents_parser_unit.sv
// Money text to signed cents.
//
// in_i  (sink):   one ASCII character per item in ch, last marks the final one.
// out_o (source): one item per text, sent for the character flagged last:
//                 cents (signed, zero unless status is ok) and status
//                 (ok, empty, bad dollars, bad cents, overflow).
//
// Pipeline: input register -> per-character update of the parse state ->
// result snapshot -> output register. A text's result reaches out_o through
// the snapshot and output registers after its last character is taken.
// Throughput is one character per cycle while in_i.ready stays high; the
// only loop is the parse state update, with the dollar accumulator (times
// ten plus a digit, done in cents). Characters that are not last never reach
// the output stages, so they keep flowing while a result waits for the receiver.
//
// Reset clears all parse state to the start of a new text and empties the
// pipeline. When the receiver stalls, the result and snapshot registers
// fill up; after that only a last character is held back in the input
// register, and in_i.ready drops until the stall clears.
module currency_text_to_cents_parser_unit (
  input logic            clk_i,
  input logic            rst_ni,
  cpt_in_if.sink         in_i,
  cpt_out_if.source      out_o
);

  // input register
  logic       v1_q;
  logic [7:0] ch_q;
  logic       last_q;

  // parse state
  cpt_pkg::state_t state_q;
  cpt_pkg::state_t step_state;

  // result snapshot
  logic          v2_q;
  cpt_pkg::fin_t fin_q;
  cpt_pkg::fin_t fin_d;

  // output register
  logic                        v3_q;
  logic [cpt_pkg::CENTS_W-1:0] cents_q;
  logic [cpt_pkg::CENTS_W-1:0] cents_d;
  cpt_pkg::status_e            status_q;
  cpt_pkg::status_e            status_d;

  logic rdy3;
  logic rdy2;
  logic adv1;
  logic take_in;

  assign rdy3    = !v3_q || out_o.ready;
  assign rdy2    = !v2_q || rdy3;
  assign adv1    = v1_q && (!last_q || rdy2);
  assign take_in = in_i.valid && in_i.ready;

  assign in_i.ready = !v1_q || adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (in_i.ready) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      ch_q   <= in_i.ch;
      last_q <= in_i.last;
    end
  end

  cpt_char_step u_step (
    .state_i (state_q),
    .ch_i    (ch_q),
    .state_o (step_state)
  );

  // a last character restarts the parse for the next text
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpt_pkg::STATE_RESET;
    end else if (adv1) begin
      state_q <= last_q ? cpt_pkg::STATE_RESET : step_state;
    end
  end

  // final classification; the magnitude range check waits for the output stage
  always_comb begin
    fin_d.neg   = step_state.neg;
    fin_d.x100  = step_state.x100;
    fin_d.cent  = step_state.cent;
    fin_d.round = step_state.round;
    priority if (step_state.phase == cpt_pkg::PH_START) begin
      fin_d.status = cpt_pkg::ST_EMPTY;
    end else if (step_state.err_dol || (step_state.paren && !step_state.close_pend)) begin
      fin_d.status = cpt_pkg::ST_BAD_DOL;
    end else if (step_state.err_cent) begin
      fin_d.status = cpt_pkg::ST_BAD_CNT;
    end else if (step_state.err_over) begin
      fin_d.status = cpt_pkg::ST_OVER;
    end else begin
      fin_d.status = cpt_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv1 && last_q) begin
      v2_q <= 1'b1;
    end else if (rdy3) begin
      v2_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && last_q) begin
      fin_q <= fin_d;
    end
  end

  // cents = +/-(dollars*100 + cents + round), overflow if above the max magnitude
  logic [6:0]                  cr;
  logic [cpt_pkg::MAG_BITS-1:0] lim;
  logic                        mag_over;
  logic [cpt_pkg::CENTS_W-1:0] mag;

  assign cr       = fin_q.cent + {6'b000000, fin_q.round};
  assign lim      = cpt_pkg::MAX_MAG - cpt_pkg::MAG_BITS'(cr);
  assign mag_over = fin_q.x100 > lim;
  assign mag      = {1'b0, fin_q.x100} + cpt_pkg::CENTS_W'(cr);

  always_comb begin
    status_d = fin_q.status;
    if ((fin_q.status == cpt_pkg::ST_OK) && mag_over) begin
      status_d = cpt_pkg::ST_OVER;
    end
    if (status_d != cpt_pkg::ST_OK) begin
      cents_d = '0;
    end else if (fin_q.neg) begin
      cents_d = '0 - mag;
    end else begin
      cents_d = mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      cents_q  <= cents_d;
      status_q <= status_d;
    end
  end

  assign out_o.valid  = v3_q;
  assign out_o.cents  = $signed(cents_q);
  assign out_o.status = status_q;

endmodule
